// ===== src/fpa_pkg.sv =====
`timescale 1ns / 1ps

package fpa_pkg;

  localparam int WORD_W            = 32;
  localparam int OP_W              = 4;
  localparam int FPA_FRAC_BITS_DEF = 8;

  localparam logic [OP_W-1:0] OP_ADD     = 4'd0;
  localparam logic [OP_W-1:0] OP_SUB     = 4'd1;
  localparam logic [OP_W-1:0] OP_MUL     = 4'd2;
  localparam logic [OP_W-1:0] OP_DIV     = 4'd3;
  localparam logic [OP_W-1:0] OP_GT      = 4'd4;
  localparam logic [OP_W-1:0] OP_GE      = 4'd5;
  localparam logic [OP_W-1:0] OP_LT      = 4'd6;
  localparam logic [OP_W-1:0] OP_LE      = 4'd7;
  localparam logic [OP_W-1:0] OP_EQ      = 4'd8;
  localparam logic [OP_W-1:0] OP_NE      = 4'd9;
  localparam logic [OP_W-1:0] OP_MIN     = 4'd10;
  localparam logic [OP_W-1:0] OP_MAX     = 4'd11;
  localparam logic [OP_W-1:0] OP_INC     = 4'd12;
  localparam logic [OP_W-1:0] OP_DEC     = 4'd13;
  localparam logic [OP_W-1:0] OP_TOINT   = 4'd14;
  localparam logic [OP_W-1:0] OP_FROMINT = 4'd15;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              cmp;
  } arith_res_t;

  typedef struct packed {
    logic [WORD_W-1:0] quotient;
    logic              dz;
  } div_res_t;

endpackage

// ===== src/fixed_point_alu_top.sv =====
`timescale 1ns / 1ps
// channel  signals                                   direction
// in       in_valid, in_ready, opcode, operand_a,   into block
//          operand_b
// out      out_valid, out_ready, result_word,        out of block
//          compare_true, status
//
// one item per cycle enters while in_ready is high; every op takes the same path length so order holds
// the divider sets the common path length and retires one quotient bit per
// stage over 32 + FRAC_BITS stages
// rst clears the valid bits only; data registers are not reset
// a stalled output register freezes the whole pipe, in_ready falls with it

module fixed_point_alu_top import fpa_pkg::*; #(
  parameter int FRAC_BITS = FPA_FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [OP_W-1:0]          opcode,
  input  logic signed [WORD_W-1:0] operand_a,
  input  logic signed [WORD_W-1:0] operand_b,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [WORD_W-1:0] result_word,
  output logic                     compare_true,
  output logic                     status
);

  localparam int DLAT = WORD_W + FRAC_BITS + 2;

  logic                     adv;
  logic [DLAT:0]            vld;
  logic [OP_W-1:0]          op0;
  logic signed [WORD_W-1:0] a0;
  logic signed [WORD_W-1:0] b0;
  logic [OP_W-1:0]          op_d [1:DLAT];
  arith_res_t               side [3:DLAT];
  arith_res_t               arith_res;
  div_res_t                 div_res;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DLAT-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op0 <= opcode;
      a0  <= operand_a;
      b0  <= operand_b;
    end
  end

  fpa_arith #(.FRAC_BITS(FRAC_BITS)) u_arith (
    .clk (clk),
    .en  (adv),
    .op  (op0),
    .a   (a0),
    .b   (b0),
    .res (arith_res)
  );

  fpa_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk (clk),
    .en  (adv),
    .a   (a0),
    .b   (b0),
    .res (div_res)
  );

  // opcode and short-path results wait for the divider
  always_ff @(posedge clk) begin
    if (adv) begin
      op_d[1] <= op0;
      for (int k = 2; k <= DLAT; k++) begin
        op_d[k] <= op_d[k-1];
      end
      side[3] <= arith_res;
      for (int k = 4; k <= DLAT; k++) begin
        side[k] <= side[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vld[DLAT];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (op_d[DLAT] == OP_DIV) begin
        result_word  <= div_res.quotient;
        compare_true <= 1'b0;
        status       <= div_res.dz;
      end else begin
        result_word  <= side[DLAT].word;
        compare_true <= side[DLAT].cmp;
        status       <= 1'b0;
      end
    end
  end

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> result_word == '0 && !compare_true)
    else $error("divide by zero item with nonzero result");

  a_cmp_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && compare_true |-> result_word == '0)
    else $error("compare item with nonzero result word");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !in_ready |=> $stable(vld))
    else $error("pipeline valid bits moved during stall");

endmodule

// ===== src/fpa_arith.sv =====
`timescale 1ns / 1ps

module fpa_arith import fpa_pkg::*; #(
  parameter int FRAC_BITS = FPA_FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [OP_W-1:0]          op,
  input  logic signed [WORD_W-1:0] a,
  input  logic signed [WORD_W-1:0] b,
  output arith_res_t               res
);

  logic signed [2*WORD_W-1:0] prod;
  logic [OP_W-1:0]            op1;
  arith_res_t                 misc1;
  arith_res_t                 misc_next;

  always_comb begin
    misc_next = '0;
    case (op)
      OP_ADD:     misc_next.word = a + b;
      OP_SUB:     misc_next.word = a - b;
      OP_GT:      misc_next.cmp  = (a > b);
      OP_GE:      misc_next.cmp  = (a >= b);
      OP_LT:      misc_next.cmp  = (a < b);
      OP_LE:      misc_next.cmp  = (a <= b);
      OP_EQ:      misc_next.cmp  = (a == b);
      OP_NE:      misc_next.cmp  = (a != b);
      OP_MIN:     misc_next.word = (a < b) ? a : b;
      OP_MAX:     misc_next.word = (a > b) ? a : b;
      OP_INC:     misc_next.word = a + WORD_W'(1);
      OP_DEC:     misc_next.word = a - WORD_W'(1);
      OP_TOINT:   misc_next.word = WORD_W'(a >>> FRAC_BITS);
      OP_FROMINT: misc_next.word = WORD_W'(a << FRAC_BITS);
      default:    misc_next = '0;
    endcase
  end

  // stage 1: full product and the simple ops
  always_ff @(posedge clk) begin
    if (en) begin
      prod  <= a * b;
      op1   <= op;
      misc1 <= misc_next;
    end
  end

  // stage 2: scale the product back to the fixed-point grid
  always_ff @(posedge clk) begin
    if (en) begin
      if (op1 == OP_MUL) begin
        res.word <= prod[FRAC_BITS+WORD_W-1:FRAC_BITS];
        res.cmp  <= 1'b0;
      end else begin
        res <= misc1;
      end
    end
  end

endmodule

// ===== src/fpa_div.sv =====
`timescale 1ns / 1ps

module fpa_div import fpa_pkg::*; #(
  parameter int FRAC_BITS = FPA_FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [WORD_W-1:0] a,
  input  logic signed [WORD_W-1:0] b,
  output div_res_t                 res
);

  localparam int NUM_W = WORD_W + FRAC_BITS;

  logic [WORD_W-1:0] rem  [0:NUM_W];
  logic [NUM_W-1:0]  quo  [0:NUM_W];
  logic [WORD_W-1:0] dvsr [0:NUM_W];
  logic              neg  [0:NUM_W];
  logic              dz   [0:NUM_W];

  logic [WORD_W-1:0] mag_a;
  logic [WORD_W-1:0] mag_b;

  assign mag_a = a[WORD_W-1] ? WORD_W'(-a) : WORD_W'(a);
  assign mag_b = b[WORD_W-1] ? WORD_W'(-b) : WORD_W'(b);

  // sign and magnitude split
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= '0;
      quo[0]  <= {mag_a, {FRAC_BITS{1'b0}}};
      dvsr[0] <= mag_b;
      neg[0]  <= a[WORD_W-1] ^ b[WORD_W-1];
      dz[0]   <= (b == '0);
    end
  end

  // one restoring step per stage, quotient bits shift in behind the numerator
  for (genvar k = 1; k <= NUM_W; k++) begin : g_step
    logic [WORD_W:0] shifted;
    logic [WORD_W:0] trial;

    assign shifted = {rem[k-1], quo[k-1][NUM_W-1]};
    assign trial   = shifted - {1'b0, dvsr[k-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]  <= trial[WORD_W] ? shifted[WORD_W-1:0] : trial[WORD_W-1:0];
        quo[k]  <= {quo[k-1][NUM_W-2:0], ~trial[WORD_W]};
        dvsr[k] <= dvsr[k-1];
        neg[k]  <= neg[k-1];
        dz[k]   <= dz[k-1];
      end
    end
  end

  // sign fix, divide by zero gives zero
  always_ff @(posedge clk) begin
    if (en) begin
      res.dz <= dz[NUM_W];
      if (dz[NUM_W]) begin
        res.quotient <= '0;
      end else if (neg[NUM_W]) begin
        res.quotient <= WORD_W'(-quo[NUM_W][WORD_W-1:0]);
      end else begin
        res.quotient <= quo[NUM_W][WORD_W-1:0];
      end
    end
  end

endmodule
